### src/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants for the set-associative LRU cache lookup block.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_BITS    = 64;

  // Set index is at least one bit wide so the row store always has an address.
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 2 ** SET_W;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LIM_W    = RANK_W + 1;
  localparam int CNT_W    = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SBITS_W    = 4;
  localparam int OFF_W      = 6;
  localparam int WAYS_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_MODIFY = 2'd2,
    FUNC_IFETCH = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic             was_miss;
    logic             evicted;
    logic [1:0]       hits_added;
    logic [CNT_W-1:0] hits_total;
    logic [CNT_W-1:0] misses_total;
    logic [CNT_W-1:0] evictions_total;
  } res_t;

  // Classified access, passed from front to back
  typedef struct packed {
    logic                 ifetch;
    logic                 modify;
    logic [SET_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] tag;
    logic [MAX_WAYS-1:0]  way_en;
  } item_t;

  typedef struct packed {
    logic                 vld;
    logic [RANK_W-1:0]    rank;
    logic [ADDR_BITS-1:0] tag;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic {
    BK_READ,
    BK_UPDATE
  } back_state_e;

endpackage

### src/salru_ram.sv
// ----------------------------------------------------------------------------
// salru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/salru_front.sv
// ----------------------------------------------------------------------------
// salru_front
// Holds the geometry registers, splits each access into set and tag and
// queues the classified access for the back end (two entries).
// ----------------------------------------------------------------------------
module salru_front import salru_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  req_t                  req_i,
  output logic                  item_vld_o,
  output item_t                 item_o,
  input  logic                  item_pop_i
);

  logic [SBITS_W-1:0] sbits_q;
  logic [OFF_W-1:0]   off_q;
  logic [WAYS_W-1:0]  ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbits_q <= '0;
      off_q   <= '0;
      ways_q  <= WAYS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SET_BITS:    sbits_q <= cfg_data_i[SBITS_W-1:0];
        REG_OFFSET_BITS: off_q   <= cfg_data_i[OFF_W-1:0];
        REG_WAYS:        ways_q  <= cfg_data_i[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Classification
  logic [SBITS_W-1:0]   sbits_eff;
  logic [WAYS_W:0]      ways_eff;
  logic [SET_W-1:0]     set_mask;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] set_raw;
  logic [OFF_W:0]       tag_sh;
  item_t                item_new;

  always_comb begin
    sbits_eff = (sbits_q > SBITS_W'(MAX_SET_BITS)) ? SBITS_W'(MAX_SET_BITS) : sbits_q;
    if (ways_q == '0) begin
      ways_eff = (WAYS_W+1)'(1);
    end else if ({1'b0, ways_q} > (WAYS_W+1)'(MAX_WAYS)) begin
      ways_eff = (WAYS_W+1)'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_q};
    end
    set_mask = ~({SET_W{1'b1}} << sbits_eff);
    addr     = req_i.address[ADDR_BITS-1:0];
    set_raw  = addr >> off_q;
    tag_sh   = {1'b0, off_q} + (OFF_W+1)'(sbits_eff);

    item_new.ifetch  = (req_i.func == FUNC_IFETCH);
    item_new.modify  = (req_i.func == FUNC_MODIFY);
    item_new.set_idx = set_raw[SET_W-1:0] & set_mask;
    item_new.tag     = addr >> tag_sh;   // shifts of 64 or more give zero
    for (int i = 0; i < MAX_WAYS; i++) begin
      item_new.way_en[i] = ((WAYS_W+1)'(i) < ways_eff);
    end
  end

  // Two-entry item queue
  item_t      q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full       = (cnt_q == 2'd2);
  assign do_push    = push && !full;
  assign do_pop     = item_pop_i && (cnt_q != 2'd0);
  assign item_vld_o = (cnt_q != 2'd0);
  assign item_o     = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= item_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### src/salru_back.sv
// ----------------------------------------------------------------------------
// salru_back
// Reads the set row, does tag match, victim choice and LRU aging, writes the
// row back, keeps the totals and queues results (two entries).
// ----------------------------------------------------------------------------
module salru_back import salru_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_vld_i,
  input  item_t item_i,
  output logic  item_pop_o,
  output logic  empty,
  input  logic  pop,
  output res_t  rsp_o
);

  back_state_e state_q, state_d;
  item_t       cur_q;
  logic        row_ok_q;               // row written at least once since reset
  logic [NUM_SETS-1:0] row_vld_q;
  logic [CNT_W-1:0] hits_q, miss_q, evict_q;

  logic res_space;
  logic res_push;
  res_t res_d;
  logic ram_re, ram_we;
  row_t rd_row, new_row;

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q.set_idx),
    .wdata_i (new_row),
    .re_i    (ram_re),
    .raddr_i (item_i.set_idx),
    .rdata_o (rd_row)
  );

  // Lookup and update of one row
  logic [MAX_WAYS-1:0] v, match, inv;
  logic [RANK_W-1:0]   r [MAX_WAYS];
  logic                hit, found, evict;
  logic [RANK_W-1:0]   hit_way, inv_way, lru_way, sel;
  logic [RANK_W-1:0]   lru_rank;
  logic [LIM_W-1:0]    limit;
  logic [1:0]          hits_add;
  logic [CNT_W:0]      hsum, msum, esum;
  logic [CNT_W-1:0]    hits_n, miss_n, evict_n;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      v[i]     = row_ok_q && rd_row[i].vld;
      r[i]     = row_ok_q ? rd_row[i].rank : '0;
      match[i] = cur_q.way_en[i] && v[i] && (rd_row[i].tag == cur_q.tag);
      inv[i]   = cur_q.way_en[i] && !v[i];
    end
    hit   = |match;
    found = |inv;

    hit_way = '0;
    inv_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) hit_way = RANK_W'(i);
      if (inv[i])   inv_way = RANK_W'(i);
    end

    // oldest way in use, lowest index on a tie
    lru_way  = '0;
    lru_rank = r[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (cur_q.way_en[i] && (r[i] > lru_rank)) begin
        lru_way  = RANK_W'(i);
        lru_rank = r[i];
      end
    end

    evict = 1'b0;
    if (hit) begin
      sel   = hit_way;
      limit = {1'b0, r[hit_way]};
    end else if (found) begin
      sel   = inv_way;
      limit = LIM_W'(MAX_WAYS);
    end else begin
      sel   = lru_way;
      limit = {1'b0, lru_rank};
      evict = 1'b1;
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      new_row[i].vld  = v[i];
      new_row[i].rank = r[i];
      new_row[i].tag  = rd_row[i].tag;
      if (cur_q.way_en[i] && (RANK_W'(i) != sel) && v[i] &&
          ({1'b0, r[i]} < limit) && (r[i] < RANK_W'(MAX_WAYS - 1))) begin
        new_row[i].rank = r[i] + RANK_W'(1);
      end
    end
    new_row[sel].rank = '0;
    if (!hit) begin
      new_row[sel].vld = 1'b1;
      new_row[sel].tag = cur_q.tag;
    end

    if (hit) hits_add = cur_q.modify ? 2'd2 : 2'd1;
    else     hits_add = cur_q.modify ? 2'd1 : 2'd0;

    hsum    = {1'b0, hits_q} + (CNT_W+1)'(hits_add);
    msum    = {1'b0, miss_q} + (CNT_W+1)'(!hit);
    esum    = {1'b0, evict_q} + (CNT_W+1)'(evict);
    hits_n  = hsum[CNT_W] ? '1 : hsum[CNT_W-1:0];
    miss_n  = msum[CNT_W] ? '1 : msum[CNT_W-1:0];
    evict_n = esum[CNT_W] ? '1 : esum[CNT_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    res_push   = 1'b0;
    res_d.was_miss        = 1'b0;
    res_d.evicted         = 1'b0;
    res_d.hits_added      = 2'd0;
    res_d.hits_total      = hits_q;
    res_d.misses_total    = miss_q;
    res_d.evictions_total = evict_q;
    case (state_q)
      BK_READ: begin
        if (item_vld_i) begin
          if (item_i.ifetch) begin
            if (res_space) begin
              item_pop_o = 1'b1;
              res_push   = 1'b1;
            end
          end else begin
            item_pop_o = 1'b1;
            ram_re     = 1'b1;
            state_d    = BK_UPDATE;
          end
        end
      end
      BK_UPDATE: begin
        if (res_space) begin
          ram_we   = 1'b1;
          res_push = 1'b1;
          res_d.was_miss        = !hit;
          res_d.evicted         = evict;
          res_d.hits_added      = hits_add;
          res_d.hits_total      = hits_n;
          res_d.misses_total    = miss_n;
          res_d.evictions_total = evict_n;
          state_d  = BK_READ;
        end
      end
      default: state_d = BK_READ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      cur_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_READ;
      row_ok_q  <= 1'b0;
      row_vld_q <= '0;
      hits_q    <= '0;
      miss_q    <= '0;
      evict_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ram_re) begin
        row_ok_q <= row_vld_q[item_i.set_idx];
      end
      if (ram_we) begin
        row_vld_q[cur_q.set_idx] <= 1'b1;
        hits_q  <= hits_n;
        miss_q  <= miss_n;
        evict_q <= evict_n;
      end
    end
  end

  // Two-entry result queue
  res_t       rq_mem [2];
  logic       rwr_q, rrd_q;
  logic [1:0] rcnt_q;
  logic       do_pop;

  assign res_space = (rcnt_q != 2'd2);
  assign empty     = (rcnt_q == 2'd0);
  assign do_pop    = pop && !empty;
  assign rsp_o     = rq_mem[rrd_q];

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rq_mem[rwr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (res_push) rwr_q <= ~rwr_q;
      if (do_pop)   rrd_q <= ~rrd_q;
      case ({res_push, do_pop})
        2'b10:   rcnt_q <= rcnt_q + 2'd1;
        2'b01:   rcnt_q <= rcnt_q - 2'd1;
        default: rcnt_q <= rcnt_q;
      endcase
    end
  end

endmodule

### src/set_assoc_lru_cache_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Set-associative cache lookup with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each access transfer (load, store, modify, instruction fetch) produces one
// result transfer. For a load, store or modify the back end reads the whole
// set row (all ways: valid, age rank, tag) from the single row RAM in BK_READ,
// then in BK_UPDATE matches tags, chooses the victim, ages the ranks and, once
// the result queue has room, writes the row back; it takes no new access
// before that read-then-write is done. An instruction fetch does no lookup
// and is answered from BK_READ. Accesses are split into set and tag on entry
// and wait in a two-entry queue, results in a second one, so push can
// continue while results are not popped, until both queues fill. Reset marks
// every set row as never written (one flag per row), so the block is ready
// right after reset with no clearing pass. Geometry registers (set_index_bits,
// offset_bits, ways_in_use) are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must do so only while no access is in flight, as the
// block does not enforce it. Index 3 is ignored. Totals saturate at all ones.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup import salru_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // access side
  input  logic                  push,
  output logic                  full,
  input  req_t                  req_i,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output res_t                  rsp_o
);

  logic  item_vld;
  item_t item;
  logic  item_pop;

  // front end: geometry, address split, item queue
  salru_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .item_vld_o (item_vld),
    .item_o     (item),
    .item_pop_i (item_pop)
  );

  // back end: row RAM, LRU update, totals, result queue
  salru_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (item_vld),
    .item_i     (item),
    .item_pop_o (item_pop),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp_o)
  );

endmodule

### src/salru_checker.sv
// ----------------------------------------------------------------------------
// salru_checker
// Port-level checks on the result side of the cache lookup block.
// ----------------------------------------------------------------------------
module salru_checker import salru_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input res_t rsp_o
);

  // a waiting result stays until it is taken
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before transfer");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(rsp_o))
    else $error("result changed while stalled");

  // an eviction only happens on a miss
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && rsp_o.evicted |-> rsp_o.was_miss)
    else $error("eviction reported without miss");

  a_hits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> rsp_o.hits_added != 2'd3)
    else $error("hits_added out of range");

  // the miss total already includes this miss
  a_miss_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && rsp_o.was_miss |-> rsp_o.misses_total != '0)
    else $error("miss total not counted");

endmodule

bind set_assoc_lru_cache_lookup salru_checker u_salru_checker (.*);
